@@ rtl/bald_pkg.sv @@
// ----------------------------------------------------------------------------
// bald_pkg: shared types and constants for the bit angle LED driver
// Item opcodes, fixed field widths and the result record.
// ----------------------------------------------------------------------------
package bald_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned CH_W     = 2;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned PIN_W    = 4;
  localparam int unsigned UNIT_W   = 16;
  localparam int unsigned PLANE_W  = 3;
  localparam int unsigned COUNT_W  = 24;

  localparam logic [UNIT_W-1:0] UNIT_RESET = 16'd40;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_SWAP  = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [PIN_W-1:0]   pin_levels;
    logic [LEVEL_W-1:0] read_level;
    logic               frame_start;
  } result_t;

endpackage

@@ rtl/bit_angle_led_driver.sv @@
// ----------------------------------------------------------------------------
// bit_angle_led_driver: binary code modulation dimmer, active-low outputs
// Double-buffered brightness stores, MSB-first bit planes, tick-driven timing.
// ----------------------------------------------------------------------------
// One beat per clock is taken while in_stall is low and yields one result beat.
// Each beat is a tick, a back-store write, a swap request or a back-store
// read; the whole update (slot counter add and compare against the plane
// length, plane step, front-store copy) is done in the cycle of acceptance.
// Results go through a two-entry output buffer, so input stalls only once
// two results are waiting; throughput is set by that buffer alone. Plane k is
// shown for unit_ticks << k ticks (0 counts as 1); pin bits are 0 when lit.
module bit_angle_led_driver
  import bald_pkg::*;
#(
  parameter int unsigned CHANNELS   = 4,
  parameter int unsigned RESOLUTION = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [UNIT_W-1:0]   cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [CH_W-1:0]     channel,
  input  logic [LEVEL_W-1:0]  level,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PIN_W-1:0]    pin_levels,
  output logic [LEVEL_W-1:0]  read_level,
  output logic                frame_start
);

  localparam int unsigned LVL_SHIFT = LEVEL_W - RESOLUTION;
  localparam int unsigned CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SHOWN     = (CHANNELS < PIN_W) ? CHANNELS : PIN_W;
  localparam logic [PLANE_W-1:0] TOP_PLANE = PLANE_W'(RESOLUTION - 1);

  logic [UNIT_W-1:0]   unit_ticks;
  logic [LEVEL_W-1:0]  front_store [CHANNELS];
  logic [LEVEL_W-1:0]  back_store  [CHANNELS];
  logic                swap_pending;
  logic                swap_pending_next;
  logic [PLANE_W-1:0]  plane_index;
  logic [PLANE_W-1:0]  plane_index_next;
  logic [COUNT_W-1:0]  slot_counter;
  logic [COUNT_W-1:0]  slot_counter_next;
  logic [CHANNELS-1:0] pin_latch;
  logic [CHANNELS-1:0] pin_latch_next;

  result_t out_res;
  result_t skid_res;
  logic    skid_valid;
  result_t res_new;

  logic                in_acc;
  logic                take_out;
  logic                ch_ok;
  logic [CH_IDX_W-1:0] ch_idx;
  logic                store_we;
  logic                do_copy;
  logic [UNIT_W-1:0]   unit_eff;
  logic [COUNT_W-1:0]  plane_len;
  logic [COUNT_W-1:0]  slot_inc;

  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !skid_valid;
  assign take_out = out_valid && !out_stall;

  assign ch_ok     = (32'(channel) < CHANNELS);
  assign ch_idx    = CH_IDX_W'(channel);
  assign unit_eff  = (unit_ticks == '0) ? UNIT_W'(1) : unit_ticks;
  assign plane_len = COUNT_W'(unit_eff) << plane_index;
  assign slot_inc  = slot_counter + COUNT_W'(1);

  always_comb begin
    pin_latch_next    = pin_latch;
    slot_counter_next = slot_counter;
    plane_index_next  = plane_index;
    swap_pending_next = swap_pending;
    do_copy           = 1'b0;
    store_we          = 1'b0;
    res_new           = '0;
    if (in_acc) begin
      unique case (opcode_t'(opcode))
        OP_TICK: begin
          if (slot_counter == '0) begin
            for (int i = 0; i < CHANNELS; i++) begin
              pin_latch_next[i] = ~front_store[i][plane_index];
            end
            res_new.frame_start = (plane_index == TOP_PLANE);
          end
          if (slot_inc >= plane_len) begin
            slot_counter_next = '0;
            if (plane_index == '0) begin
              // end of frame: restart at the top plane, apply a pending swap
              plane_index_next = TOP_PLANE;
              if (swap_pending) begin
                do_copy           = 1'b1;
                swap_pending_next = 1'b0;
              end
            end else begin
              plane_index_next = plane_index - PLANE_W'(1);
            end
          end else begin
            slot_counter_next = slot_inc;
          end
        end
        OP_WRITE: store_we = ch_ok;
        OP_SWAP:  swap_pending_next = 1'b1;
        OP_READ: begin
          if (ch_ok) begin
            res_new.read_level = LEVEL_W'(back_store[ch_idx] << LVL_SHIFT);
          end
        end
        default: ;
      endcase
    end
    for (int i = 0; i < SHOWN; i++) begin
      res_new.pin_levels[i] = pin_latch_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks   <= UNIT_RESET;
      swap_pending <= 1'b0;
      plane_index  <= TOP_PLANE;
      slot_counter <= '0;
      pin_latch    <= '1;
      for (int i = 0; i < CHANNELS; i++) begin
        front_store[i] <= '0;
        back_store[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        unit_ticks <= cfg_wdata;
      end
      swap_pending <= swap_pending_next;
      plane_index  <= plane_index_next;
      slot_counter <= slot_counter_next;
      pin_latch    <= pin_latch_next;
      if (store_we) begin
        back_store[ch_idx] <= LEVEL_W'(level >> LVL_SHIFT);
      end
      if (do_copy) begin
        for (int i = 0; i < CHANNELS; i++) begin
          front_store[i] <= back_store[i];
        end
      end
    end
  end

  // two-entry output buffer: main register plus skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || take_out) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_acc;
        end
      end else if (in_acc) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take_out) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (in_acc) begin
        out_res <= res_new;
      end
    end else if (in_acc) begin
      skid_res <= res_new;
    end
  end

  assign pin_levels  = out_res.pin_levels;
  assign read_level  = out_res.read_level;
  assign frame_start = out_res.frame_start;

endmodule

@@ rtl/bald_checker.sv @@
// ----------------------------------------------------------------------------
// bald_checker: port-level checks for the bit angle LED driver
// Watches the handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module bald_checker
  import bald_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [PIN_W-1:0]    pin_levels,
  input logic [LEVEL_W-1:0]  read_level,
  input logic                frame_start
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pin_levels)
      && $stable(read_level) && $stable(frame_start))
    else $error("stalled result beat changed");

  // input backs up only behind a waiting result
  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // an accepted beat into an empty output shows up next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> out_valid)
    else $error("accepted beat did not reach output");

  // frame start comes from a tick only, read data from a read only
  a_fs_no_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_start |-> read_level == '0)
    else $error("frame start with read data");

endmodule

bind bit_angle_led_driver bald_checker u_bald_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .pin_levels (pin_levels),
  .read_level (read_level),
  .frame_start(frame_start)
);
